>>> hw/rtl/rvm_pkg.sv
// ----------------------------------------------------------------------------
// rvm_pkg
// Shared types and constants of the rotation vector to matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvm_pkg;

  // number of series terms in each coefficient chain
  localparam int unsigned TERMS       = 20;
  // register stages in one series term
  localparam int unsigned STEP_STAGES = 6;

  // squared norm width (q6.26) and its truncated q6.16 form
  localparam int unsigned SQ_W   = 32;
  localparam int unsigned S16_W  = 22;
  // coefficient width (q28, signed)
  localparam int unsigned U_W    = 32;
  // scaled product and quotient widths of one series term
  localparam int unsigned P_W    = S16_W + 1 + U_W;
  localparam int unsigned N_W    = P_W - 1 - 16;
  localparam int unsigned NH_W   = N_W / 2;
  localparam int unsigned DIV_SHIFT = N_W;
  localparam int unsigned RECIP_W = 36;
  localparam int unsigned DEN_W   = 11;

  localparam logic [U_W-1:0] ONE_Q28 = U_W'(32'h1000_0000);

  // input transfer: rotation vector, q3.13
  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
  } rot_vec_t;

  // result transfer: rotation matrix, q2.14, row major
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rot_mat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rvm_series_step.sv
// ----------------------------------------------------------------------------
// rvm_series_step
// One horner term u' = 1 - trunc(s16 * u / (DEN * 2^16)), six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rvm_series_step #(
  parameter int unsigned DEN = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        vld_i,
  input  wire logic [rvm_pkg::S16_W-1:0]   s16_i,
  input  wire logic [rvm_pkg::U_W-1:0]     u_i,
  output logic                             vld_o,
  output logic [rvm_pkg::S16_W-1:0]        s16_o,
  output logic [rvm_pkg::U_W-1:0]          u_o
);
  import rvm_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / 64'(DEN));
  localparam logic [DEN_W-1:0]   DEN_C = DEN_W'(DEN);

  logic [STEP_STAGES-1:0] vld_q;
  logic [S16_W-1:0]       s16_q [STEP_STAGES];

  logic signed [P_W-1:0]  s16_x, u_x, p_d, p_q;
  logic [P_W-1:0]         mag;
  logic [N_W-1:0]         n_d, n2_q, n3_q, n4_q;
  logic                   neg2_q, neg3_q, neg4_q, neg5_q;
  logic [NH_W+RECIP_W-1:0] lo_d, hi_d, lo_q, hi_q, lo_x, hi_x;
  logic [N_W+RECIP_W-1:0] prod;
  logic [RECIP_W-1:0]     q0_d, q0_q, q_d, q_q;
  logic [RECIP_W+DEN_W-1:0] qd;
  logic [N_W-1:0]         rem;
  logic [N_W-1:0]         one_x, u_full;

  // valid and s16 travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STEP_STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s16_q[0] <= s16_i;
    for (int i = 1; i < STEP_STAGES; i++) begin
      s16_q[i] <= s16_q[i-1];
    end
  end

  // stage 1: scaled product
  always_comb begin
    s16_x = signed'({(P_W-S16_W)'(0), s16_i});
    u_x   = P_W'(signed'(u_i));
    p_d   = s16_x * u_x;
  end

  // stage 2: magnitude, drop the 2^16 scale
  always_comb begin
    mag = p_q[P_W-1] ? P_W'(-p_q) : P_W'(p_q);
    n_d = mag[P_W-2:16];
  end

  // stage 3: reciprocal partial products
  always_comb begin
    lo_x = (NH_W+RECIP_W)'(n2_q[NH_W-1:0]);
    hi_x = (NH_W+RECIP_W)'(n2_q[N_W-1:NH_W]);
    lo_d = lo_x * (NH_W+RECIP_W)'(RECIP);
    hi_d = hi_x * (NH_W+RECIP_W)'(RECIP);
  end

  // stage 4: quotient estimate, low by at most one
  always_comb begin
    prod = ((N_W+RECIP_W)'(hi_q) << NH_W) + (N_W+RECIP_W)'(lo_q);
    q0_d = prod[N_W+RECIP_W-1:DIV_SHIFT];
  end

  // stage 5: remainder check and correction
  always_comb begin
    qd  = (RECIP_W+DEN_W)'(q0_q) * (RECIP_W+DEN_W)'(DEN_C);
    rem = n4_q - N_W'(qd);
    q_d = (rem >= N_W'(DEN_C)) ? q0_q + RECIP_W'(1) : q0_q;
  end

  // stage 6: next coefficient
  always_comb begin
    one_x  = N_W'(ONE_Q28);
    u_full = neg5_q ? one_x + N_W'(q_q) : one_x - N_W'(q_q);
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    n2_q   <= n_d;
    neg2_q <= p_q[P_W-1];
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    n3_q   <= n2_q;
    neg3_q <= neg2_q;
    q0_q   <= q0_d;
    n4_q   <= n3_q;
    neg4_q <= neg3_q;
    q_q    <= q_d;
    neg5_q <= neg4_q;
    u_o    <= u_full[U_W-1:0];
  end

  assign vld_o = vld_q[STEP_STAGES-1];
  assign s16_o = s16_q[STEP_STAGES-1];

endmodule

`default_nettype wire

>>> hw/rtl/rotation_vector_to_matrix_unit.sv
// ----------------------------------------------------------------------------
// rotation_vector_to_matrix_unit
// Rotation vector (q3.13) to 3x3 rotation matrix (q2.14) by the rodrigues
// formula, fully pipelined.
// ----------------------------------------------------------------------------
// A vector is taken on every clock edge where start is high; busy is always
// low, so one vector per cycle is accepted with no gaps. Each matrix appears
// on result_o with done_o high for one cycle, once its vector has passed
// the pipeline (1 input stage, 2 norm stages, 120 stages of the two
// 20-term coefficient chains at 6 stages per term, 4 matrix stages). The
// receiver cannot stall, so results must be captured when done_o is high.
// Results leave in the order the vectors arrived.
`default_nettype none

module rotation_vector_to_matrix_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire rvm_pkg::rot_vec_t vec_i,
  output logic                   done_o,
  output rvm_pkg::rot_mat_t      result_o
);
  import rvm_pkg::*;

  localparam int unsigned DL_DEPTH = TERMS * STEP_STAGES;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [SQ_W-1:0]    s;
  } side_t;

  // front end: input register, squares, norm
  logic          p0_vld_q, p1_vld_q, p2_vld_q;
  rot_vec_t      v0_q, v1_q;
  logic [30:0]   sqx_q, sqy_q, sqz_q;
  logic signed [31:0] sqx_d, sqy_d, sqz_d;
  logic [SQ_W-1:0] s2_q;
  rot_vec_t      v2_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else begin
      p0_vld_q <= start & ~busy;
      p1_vld_q <= p0_vld_q;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_comb begin
    sqx_d = v0_q.rot_x * v0_q.rot_x;
    sqy_d = v0_q.rot_y * v0_q.rot_y;
    sqz_d = v0_q.rot_z * v0_q.rot_z;
  end

  always_ff @(posedge clk_i) begin
    v0_q  <= vec_i;
    v1_q  <= v0_q;
    sqx_q <= sqx_d[30:0];
    sqy_q <= sqy_d[30:0];
    sqz_q <= sqz_d[30:0];
    v2_q  <= v1_q;
    s2_q  <= SQ_W'(sqx_q) + SQ_W'(sqy_q) + SQ_W'(sqz_q);
  end

  // coefficient chains: sin(t)/t and 2(1-cos t)/t^2
  logic             a_vld [TERMS+1];
  logic [S16_W-1:0] a_s16 [TERMS+1];
  logic [U_W-1:0]   a_u   [TERMS+1];
  logic             b_vld [TERMS+1];
  logic [S16_W-1:0] b_s16 [TERMS+1];
  logic [U_W-1:0]   b_u   [TERMS+1];

  assign a_vld[0] = p2_vld_q;
  assign a_s16[0] = s2_q[SQ_W-1:SQ_W-S16_W];
  assign a_u[0]   = ONE_Q28;
  assign b_vld[0] = p2_vld_q;
  assign b_s16[0] = s2_q[SQ_W-1:SQ_W-S16_W];
  assign b_u[0]   = ONE_Q28;

  for (genvar g = 0; g < TERMS; g++) begin : g_term
    localparam int unsigned K    = TERMS - g;
    localparam int unsigned DEN_A = (2 * K) * (2 * K + 1);
    localparam int unsigned DEN_B = (2 * K + 1) * (2 * K + 2);

    rvm_series_step #(.DEN(DEN_A)) u_step_a (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (a_vld[g]),
      .s16_i  (a_s16[g]),
      .u_i    (a_u[g]),
      .vld_o  (a_vld[g+1]),
      .s16_o  (a_s16[g+1]),
      .u_o    (a_u[g+1])
    );

    rvm_series_step #(.DEN(DEN_B)) u_step_b (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (b_vld[g]),
      .s16_i  (b_s16[g]),
      .u_i    (b_u[g]),
      .vld_o  (b_vld[g+1]),
      .s16_o  (b_s16[g+1]),
      .u_o    (b_u[g+1])
    );
  end

  // vector and norm delay line, aligned with the chains
  side_t dl_q [DL_DEPTH];

  always_ff @(posedge clk_i) begin
    dl_q[0] <= {v2_q.rot_x, v2_q.rot_y, v2_q.rot_z, s2_q};
    for (int i = 1; i < DL_DEPTH; i++) begin
      dl_q[i] <= dl_q[i-1];
    end
  end

  logic  chain_vld;
  side_t side;
  assign chain_vld = a_vld[TERMS];
  assign side      = dl_q[DL_DEPTH-1];

  // matrix back end
  logic f1_vld_q, f2_vld_q, f3_vld_q, done_q;
  logic signed [16:0] w_ent [9];
  logic signed [15:0] vc [3];
  logic signed [48:0] aw_d [9];
  logic signed [48:0] aw1_q [9], aw2_q [9], aw3_q [9];
  logic signed [31:0] vv_d [9];
  logic signed [31:0] vv_q [9];
  logic signed [33:0] sq_d [9];
  logic signed [33:0] sq_q [9];
  logic signed [63:0] bsq_d [9];
  logic signed [63:0] bsq_q [9];
  logic signed [U_W-1:0] b1_q, b2_q;
  logic [SQ_W-1:0]   s1_q;
  logic signed [15:0] ent_d [9];
  rot_mat_t          res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      f1_vld_q <= chain_vld;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
      done_q   <= f3_vld_q;
    end
  end

  // skew matrix of the vector
  always_comb begin
    vc[0] = side.x;
    vc[1] = side.y;
    vc[2] = side.z;
    w_ent[0] = '0;
    w_ent[1] = -17'(side.z);
    w_ent[2] = 17'(side.y);
    w_ent[3] = 17'(side.z);
    w_ent[4] = '0;
    w_ent[5] = -17'(side.x);
    w_ent[6] = -17'(side.y);
    w_ent[7] = 17'(side.x);
    w_ent[8] = '0;
  end

  for (genvar e = 0; e < 9; e++) begin : g_ent
    localparam int unsigned RI = e / 3;
    localparam int unsigned CJ = e % 3;
    localparam bit          DIAG = (RI == CJ);

    logic signed [48:0] a_x, w_x;
    logic signed [63:0] b_x, sq_x, acc;
    logic signed [22:0] r;

    // stage f1: a * w and v_i * v_j
    always_comb begin
      a_x     = 49'(signed'(a_u[TERMS]));
      w_x     = 49'(w_ent[e]);
      aw_d[e] = a_x * w_x;
      vv_d[e] = vc[RI] * vc[CJ];
    end

    // stage f2: w^2 term, diagonal takes off the norm
    always_comb begin
      if (DIAG) begin
        sq_d[e] = 34'(vv_q[e]) - signed'({2'b00, s1_q});
      end else begin
        sq_d[e] = 34'(vv_q[e]);
      end
    end

    // stage f3: b * w^2 term
    always_comb begin
      b_x      = 64'(b2_q);
      sq_x     = 64'(sq_q[e]);
      bsq_d[e] = b_x * sq_x;
    end

    // stage f4: sum in q55, round half up to q14, saturate
    always_comb begin
      acc = (64'(aw3_q[e]) <<< 14) + bsq_q[e] + (64'sd1 <<< 40);
      if (DIAG) begin
        acc = acc + (64'sd1 <<< 55);
      end
      r = acc[63:41];
      if (r > 23'sd32767) begin
        ent_d[e] = 16'sh7fff;
      end else if (r < -23'sd32768) begin
        ent_d[e] = 16'sh8000;
      end else begin
        ent_d[e] = r[15:0];
      end
    end

    always_ff @(posedge clk_i) begin
      aw1_q[e] <= aw_d[e];
      vv_q[e]  <= vv_d[e];
      aw2_q[e] <= aw1_q[e];
      sq_q[e]  <= sq_d[e];
      aw3_q[e] <= aw2_q[e];
      bsq_q[e] <= bsq_d[e];
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q <= signed'(b_u[TERMS]);
    s1_q <= side.s;
    b2_q <= b1_q;
    res_q.m00 <= ent_d[0];
    res_q.m01 <= ent_d[1];
    res_q.m02 <= ent_d[2];
    res_q.m10 <= ent_d[3];
    res_q.m11 <= ent_d[4];
    res_q.m12 <= ent_d[5];
    res_q.m20 <= ent_d[6];
    res_q.m21 <= ent_d[7];
    res_q.m22 <= ent_d[8];
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // both chains run in lock step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld[TERMS] == b_vld[TERMS])
    else $error("coefficient chains out of step");

  // zero norm gives a = 1 and b = 1 exactly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_vld && side.s == '0) |-> (a_u[TERMS] == ONE_Q28 && b_u[TERMS] == ONE_Q28))
    else $error("zero vector coefficients wrong");

  // the sin coefficient stays within its headroom
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_vld |-> (signed'(a_u[TERMS]) <= 32'sh2000_0000 &&
                   signed'(a_u[TERMS]) >= -32'sh2000_0000))
    else $error("sin coefficient out of range");

  // every transfer out comes from a chain result, registered through f1_vld_q, f2_vld_q, f3_vld_q and done_q
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(chain_vld, 4))
    else $error("result without coefficient");

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rotation_vector_to_matrix_unit: a bit-exact Rodrigues
// predictor fills a queue of expected matrices, each done_o is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rvm_pkg::*;

  localparam int LATENCY   = 127;
  localparam int MAX_CYCLE = 400000;

  // expected matrices and their comparison
  class matrix_board;
    rot_mat_t pending[$];
    int       mismatches;

    // series coefficient in q28, off 0 gives sin t/t, off 1 gives 2(1-cos t)/t^2
    function longint coeff(longint s16, longint off);
      longint u;
      longint lo;
      u = 64'sd1 << 28;
      for (longint k = TERMS; k >= 1; k--) begin
        lo = 2 * k + off;
        u = (64'sd1 << 28) - (s16 * u) / (lo * (lo + 1) * 65536);
      end
      return u;
    endfunction

    function void note_vector(rot_vec_t vec);
      longint v[3];
      longint w[3][3];
      longint s, a, b, acc, r;
      logic signed [15:0] m[9];
      rot_mat_t res;
      v[0] = vec.rot_x;
      v[1] = vec.rot_y;
      v[2] = vec.rot_z;
      s = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      w[0][0] = 0;     w[0][1] = -v[2]; w[0][2] = v[1];
      w[1][0] = v[2];  w[1][1] = 0;     w[1][2] = -v[0];
      w[2][0] = -v[1]; w[2][1] = v[0];  w[2][2] = 0;
      // zero vector takes the small-angle form
      if (s == 0) begin
        a = 64'sd1 << 28;
        b = 64'sd1 << 28;
      end else begin
        a = coeff(s >>> 10, 0);
        b = coeff(s >>> 10, 1);
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc = (i == j) ? (64'sd1 << 55) : 0;
          acc += a * w[i][j] * 16384;
          acc += b * (v[i] * v[j] - ((i == j) ? s : 0));
          // arithmetic shift is floor division
          r = (acc + (64'sd1 << 40)) >>> 41;
          if (r > 32767) r = 32767;
          if (r < -32768) r = -32768;
          m[i * 3 + j] = r[15:0];
        end
      end
      res = '{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
      pending.insert(pending.size(), res);
    endfunction

    function void check_matrix(rot_mat_t got);
      rot_mat_t want;
      logic [15:0] wf[9];
      logic [15:0] gf[9];
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected matrix %h", got);
        return;
      end
      want = pending.pop_front();
      bad = 0;
      {wf[0], wf[1], wf[2], wf[3], wf[4], wf[5], wf[6], wf[7], wf[8]} = want;
      {gf[0], gf[1], gf[2], gf[3], gf[4], gf[5], gf[6], gf[7], gf[8]} = got;
      for (int f = 0; f < 9; f++) begin
        if (wf[f] !== gf[f]) begin
          bad = 1;
          if (mismatches < 10)
            $display("m%0d%0d: expected %h got %h", f / 3, f % 3, wf[f], gf[f]);
        end
      end
      if (bad) mismatches++;
    endfunction
  endclass

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     start = 0;
  logic     busy;
  rot_vec_t vec_i = '0;
  logic     done_o;
  rot_mat_t result_o;
  int       sender_idle = 0;
  longint   cycle = 0;
  matrix_board board = new();

  rotation_vector_to_matrix_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .vec_i(vec_i), .done_o(done_o), .result_o(result_o)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // result capture and run limit
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni && done_o) board.check_matrix(result_o);
    if (cycle > MAX_CYCLE) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one transfer, with random idle cycles first; start stays high afterwards
  task automatic send_vector(rot_vec_t vec);
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1;
    vec_i <= vec;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_vector(vec);
  endtask

  function automatic logic [15:0] rnd_comp();
    case ($urandom_range(5))
      0:       return 16'(32'($urandom_range(15)) - 8);
      1:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
      2:       return 16'(32'($urandom_range(16384)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] ext[6];
    int idle_mix[4];
    ext = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h2000};
    idle_mix = '{0, 50, 0, 33};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: zero, tiny, full scale and mixed extremes
    for (int d = 0; d < 24; d++) begin
      if (d < 6) send_vector('{ext[d], 16'h0000, 16'h0000});
      else if (d < 12) send_vector('{16'h0000, ext[d - 6], ext[d - 6]});
      else if (d < 18) send_vector('{ext[d - 12], ext[d - 12], ext[d - 12]});
      else send_vector('{ext[d - 18], ext[(d + 3) % 6], ext[(d + 1) % 6]});
    end
    // hold off until the pipeline is drained
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle = idle_mix[ph];
      for (int n = 0; n < 310; n++) send_vector('{rnd_comp(), rnd_comp(), rnd_comp()});
    end
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
